### hw/rtl/pmct_pkg.sv
`timescale 1ns / 1ps

package pmct_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int BUTTON_BITS = 3;

    // register indexes on the configuration port
    localparam logic REG_MAX_X = 1'b0;
    localparam logic REG_MAX_Y = 1'b1;

    // head byte bit that is always set in a valid packet
    localparam logic [BYTE_BITS-1:0] SYNC_MASK = 8'h08;

    typedef struct packed {
        logic [BUTTON_BITS-1:0] buttons;
        logic [BYTE_BITS-1:0]   dx;
        logic [BYTE_BITS-1:0]   dy;
    } t_packet;

endpackage

### hw/rtl/pmct_in_if.sv
`timescale 1ns / 1ps

interface pmct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       from_aux;

    modport source (output valid, output rx_byte, output from_aux, input ready);
    modport sink (input valid, input rx_byte, input from_aux, output ready);
endinterface

### hw/rtl/pmct_out_if.sv
`timescale 1ns / 1ps

interface pmct_out_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [2:0]            button_bits;

    modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                    input ready);
    modport sink (input valid, input cursor_x, input cursor_y, input button_bits,
                  output ready);
endinterface

### hw/rtl/ps2_mouse_packet_cursor_tracker_top.sv
// a byte request is registered in the input reg; its cursor result in the result reg
// throughput: one byte request per cycle while results are taken
// the cursor add/clamp and packet framing are combinational between the regs
// reset: synchronous active low; bounds 639/479, cursor centered, framing idle
// bound writes recenter that axis at once; framing is left as it is
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_top
    import pmct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    pmct_in_if.sink               i_req,
    pmct_out_if.source            o_rsp
);

    logic                 r_in_valid;
    logic [BYTE_BITS-1:0] r_in_byte;
    logic                 r_in_aux;

    logic                   r_out_valid;
    logic [COORD_BITS-1:0]  r_out_x;
    logic [COORD_BITS-1:0]  r_out_y;
    logic [BUTTON_BITS-1:0] r_out_btn;

    logic                  pkt_done;
    t_packet               pkt;
    logic [COORD_BITS-1:0] next_x;
    logic [COORD_BITS-1:0] next_y;
    logic                  out_free;
    logic                  consume;
    logic                  emit;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign consume     = r_in_valid && (!pkt_done || out_free);
    assign emit        = consume && pkt_done;
    assign i_req.ready = !r_in_valid || consume;

    pmct_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (consume),
        .i_rx_byte  (r_in_byte),
        .i_from_aux (r_in_aux),
        .o_done     (pkt_done),
        .o_pkt      (pkt)
    );

    pmct_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_move     (emit),
        .i_pkt      (pkt),
        .o_next_x   (next_x),
        .o_next_y   (next_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_byte <= i_req.rx_byte;
            r_in_aux  <= i_req.from_aux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x   <= next_x;
            r_out_y   <= next_y;
            r_out_btn <= pkt.buttons;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.cursor_x    = r_out_x;
    assign o_rsp.cursor_y    = r_out_y;
    assign o_rsp.button_bits = r_out_btn;

endmodule

### hw/rtl/pmct_framer.sv
`timescale 1ns / 1ps

module pmct_framer
    import pmct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [BYTE_BITS-1:0] i_rx_byte,
    input  logic                 i_from_aux,
    output logic                 o_done,
    output t_packet              o_pkt
);

    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_DX   = 2'd1;
    localparam logic [1:0] PH_DY   = 2'd2;

    logic [1:0]           r_phase;
    logic [1:0]           n_phase;
    logic [BYTE_BITS-1:0] r_head;
    logic [BYTE_BITS-1:0] n_head;
    logic [BYTE_BITS-1:0] r_dx;
    logic [BYTE_BITS-1:0] n_dx;

    always_comb begin
        n_phase = r_phase;
        n_head  = r_head;
        n_dx    = r_dx;
        o_done  = 1'b0;
        if (i_from_aux) begin
            case (r_phase)
                PH_DX: begin
                    n_dx    = i_rx_byte;
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    n_phase = PH_HEAD;
                    o_done  = 1'b1;
                end
                default: begin
                    // resync: wait for a head byte with the sync bit set
                    if ((i_rx_byte & SYNC_MASK) != '0) begin
                        n_head  = i_rx_byte;
                        n_phase = PH_DX;
                    end else begin
                        n_phase = PH_HEAD;
                    end
                end
            endcase
        end
    end

    assign o_pkt.buttons = r_head[BUTTON_BITS-1:0];
    assign o_pkt.dx      = r_dx;
    assign o_pkt.dy      = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_head  <= '0;
            r_dx    <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_head  <= n_head;
            r_dx    <= n_dx;
        end
    end

endmodule

### hw/rtl/pmct_cursor.sv
`timescale 1ns / 1ps

module pmct_cursor
    import pmct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    input  logic                  i_move,
    input  t_packet               i_pkt,
    output logic [COORD_BITS-1:0] o_next_x,
    output logic [COORD_BITS-1:0] o_next_y
);

    localparam int SUM_BITS = COORD_BITS + 2;
    localparam logic [COORD_BITS-1:0] MAX_X_RESET = COORD_BITS'(639);
    localparam logic [COORD_BITS-1:0] MAX_Y_RESET = COORD_BITS'(479);

    logic [COORD_BITS-1:0] r_max_x;
    logic [COORD_BITS-1:0] r_max_y;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;

    logic signed [SUM_BITS-1:0] sum_x;
    logic signed [SUM_BITS-1:0] sum_y;

    assign sum_x = $signed({2'b00, r_pos_x})
                 + SUM_BITS'($signed(i_pkt.dx));
    assign sum_y = $signed({2'b00, r_pos_y})
                 - SUM_BITS'($signed(i_pkt.dy));

    always_comb begin
        if (sum_x[SUM_BITS-1]) begin
            o_next_x = '0;
        end else if (sum_x[SUM_BITS-2:0] > {1'b0, r_max_x}) begin
            o_next_x = r_max_x;
        end else begin
            o_next_x = sum_x[COORD_BITS-1:0];
        end
        if (sum_y[SUM_BITS-1]) begin
            o_next_y = '0;
        end else if (sum_y[SUM_BITS-2:0] > {1'b0, r_max_y}) begin
            o_next_y = r_max_y;
        end else begin
            o_next_y = sum_y[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= MAX_X_RESET;
            r_max_y <= MAX_Y_RESET;
            r_pos_x <= MAX_X_RESET >> 1;
            r_pos_y <= MAX_Y_RESET >> 1;
        end else if (i_cfg_we) begin
            // bound write recenters that axis
            if (i_cfg_idx == REG_MAX_X) begin
                r_max_x <= i_cfg_data;
                r_pos_x <= i_cfg_data >> 1;
            end else begin
                r_max_y <= i_cfg_data;
                r_pos_y <= i_cfg_data >> 1;
            end
        end else if (i_move) begin
            r_pos_x <= o_next_x;
            r_pos_y <= o_next_y;
        end
    end

endmodule
